// ===== rtl/prc_pkg.sv =====
package prc_pkg;

   localparam int TILT_WIDTH  = 12;
   localparam int HOLD_WIDTH  = 8;
   localparam int IDLE_WIDTH  = 10;
   localparam int TICK_WIDTH  = 9;
   localparam int ADDR_WIDTH  = 4;
   localparam int DATA_WIDTH  = 32;

   localparam logic [TILT_WIDTH-1:0] TILT_LOW_RESET     = 12'h175;
   localparam logic [TILT_WIDTH-1:0] TILT_HIGH_RESET    = 12'hE70;
   localparam logic [HOLD_WIDTH-1:0] KEY_MIN_HOLD_RESET = 8'd8;
   localparam logic [IDLE_WIDTH-1:0] IDLE_LIMIT_RESET   = 10'd1000;
   localparam logic [HOLD_WIDTH-1:0] KEY_HOLD_CAP       = 8'd200;

   localparam logic [1:0] REG_TILT_LOW     = 2'd0;
   localparam logic [1:0] REG_TILT_HIGH    = 2'd1;
   localparam logic [1:0] REG_KEY_MIN_HOLD = 2'd2;
   localparam logic [1:0] REG_IDLE_LIMIT   = 2'd3;

   localparam logic [1:0] CHARGE_NONE = 2'd0;
   localparam logic [1:0] CHARGE_BUSY = 2'd1;
   localparam logic [1:0] CHARGE_FULL = 2'd2;

   typedef enum logic [1:0] {
      VIBE_NONE    = 2'd0,
      VIBE_STARTUP = 2'd1,
      VIBE_REMIND  = 2'd2
   } vibe_type;

   localparam int STARTUP_WINDOWS = 7;
   localparam int REMIND_WINDOWS  = 24;

   localparam logic [TICK_WIDTH-1:0] STARTUP_WIN [STARTUP_WINDOWS] = '{
      9'd24, 9'd45, 9'd68, 9'd89, 9'd111, 9'd142, 9'd174
   };

   localparam logic [TICK_WIDTH-1:0] REMIND_WIN [REMIND_WINDOWS] = '{
      9'd79,  9'd90,  9'd95,  9'd112, 9'd115, 9'd129, 9'd164, 9'd175,
      9'd180, 9'd197, 9'd200, 9'd214, 9'd249, 9'd260, 9'd265, 9'd282,
      9'd285, 9'd300, 9'd333, 9'd344, 9'd350, 9'd366, 9'd370, 9'd384
   };

   typedef struct packed {
      logic [TILT_WIDTH-1:0] tilt_low;
      logic [TILT_WIDTH-1:0] tilt_high;
      logic [HOLD_WIDTH-1:0] key_min_hold;
      logic [IDLE_WIDTH-1:0] idle_limit;
   } cfg_type;

   typedef struct packed {
      logic                  key_down;
      logic                  charging;
      logic                  charge_full;
      logic [TILT_WIDTH-1:0] accel_z_first;
      logic [TILT_WIDTH-1:0] accel_z_second;
   } item_type;

   typedef struct packed {
      logic                  work_enabled;
      vibe_type              vibe_mode;
      logic [TICK_WIDTH-1:0] pattern_ticks;
      logic                  motor_level;
      logic [HOLD_WIDTH-1:0] key_hold_count;
      logic [IDLE_WIDTH-1:0] idle_count;
   } state_type;

   typedef struct packed {
      logic       motor_on;
      logic       working;
      logic [1:0] charge_state;
      logic       key_toggle;
      logic       tilt_seen;
      logic       sleep_request;
   } result_type;

   typedef struct packed {
      logic found;
      logic on;
   } pattern_type;

   function automatic logic in_band(input logic [TILT_WIDTH-1:0] z,
                                    input cfg_type cfg);
      return (z > cfg.tilt_low) && (z < cfg.tilt_high);
   endfunction

   function automatic pattern_type pattern_lookup(input logic remind,
                                                  input logic [TICK_WIDTH-1:0] ticks);
      pattern_type res;
      res = '0;
      if (remind) begin
         for (int i = REMIND_WINDOWS - 1; i >= 0; i--) begin
            if (ticks < REMIND_WIN[i]) begin
               res.found = 1'b1;
               res.on    = i[0];
            end
         end
      end else begin
         for (int i = STARTUP_WINDOWS - 1; i >= 0; i--) begin
            if (ticks < STARTUP_WIN[i]) begin
               res.found = 1'b1;
               res.on    = ~i[0];
            end
         end
      end
      return res;
   endfunction

endpackage

// ===== rtl/posture_reminder_controller_unit.sv =====
// channel  direction  ports                                          handshake
// req      in         req_key_down req_charging req_charge_full      req_valid/req_ready
//                     req_accel_z_first req_accel_z_second
// rsp      out        rsp_motor_on rsp_working rsp_charge_state      rsp_valid/rsp_ready
//                     rsp_key_toggle rsp_tilt_seen rsp_sleep_request
// csr      in/out     APB-style, 4 registers at byte offsets 0, 4, 8, 12
//
// An item is captured in the input register, evaluated combinationally against the
// controller state and lands in the result register. One item per cycle is sustained
// unless the result stalls; the state register closes the loop from one item to the next.
// Synchronous reset clears the state and both valid flags and loads the configuration defaults.
// A stalled result holds the result register and, behind it, the input register.
module posture_reminder_controller_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_key_down,
   input  logic                            req_charging,
   input  logic                            req_charge_full,
   input  logic [prc_pkg::TILT_WIDTH-1:0]  req_accel_z_first,
   input  logic [prc_pkg::TILT_WIDTH-1:0]  req_accel_z_second,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_motor_on,
   output logic                            rsp_working,
   output logic [1:0]                      rsp_charge_state,
   output logic                            rsp_key_toggle,
   output logic                            rsp_tilt_seen,
   output logic                            rsp_sleep_request,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [prc_pkg::ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [prc_pkg::DATA_WIDTH-1:0]  csr_pwdata,
   output logic [prc_pkg::DATA_WIDTH-1:0]  csr_prdata,
   output logic                            csr_pready
);

   prc_pkg::cfg_type    cfg;
   prc_pkg::item_type   item_ff;
   prc_pkg::state_type  state_ff;
   prc_pkg::state_type  state_in;
   prc_pkg::result_type result_in;
   prc_pkg::result_type rsp_ff;
   logic                item_valid_ff;
   logic                rsp_valid_ff;
   logic                advance;
   logic                fire;

   prc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   prc_tick u_tick (
      .cfg        (cfg),
      .item       (item_ff),
      .state      (state_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = item_valid_ff && advance;
   assign req_ready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff           <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         state_ff.work_enabled   <= 1'b0;
         state_ff.vibe_mode      <= prc_pkg::VIBE_NONE;
         state_ff.pattern_ticks  <= '0;
         state_ff.motor_level    <= 1'b0;
         state_ff.key_hold_count <= '0;
         state_ff.idle_count     <= '0;
      end else begin
         if (req_ready) begin
            item_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= item_valid_ff;
         end
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff.key_down       <= req_key_down;
         item_ff.charging       <= req_charging;
         item_ff.charge_full    <= req_charge_full;
         item_ff.accel_z_first  <= req_accel_z_first;
         item_ff.accel_z_second <= req_accel_z_second;
      end
      if (fire) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_motor_on      = rsp_ff.motor_on;
   assign rsp_working       = rsp_ff.working;
   assign rsp_charge_state  = rsp_ff.charge_state;
   assign rsp_key_toggle    = rsp_ff.key_toggle;
   assign rsp_tilt_seen     = rsp_ff.tilt_seen;
   assign rsp_sleep_request = rsp_ff.sleep_request;

endmodule

// ===== rtl/prc_csr.sv =====
module prc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [prc_pkg::ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [prc_pkg::DATA_WIDTH-1:0]  csr_pwdata,
   output logic [prc_pkg::DATA_WIDTH-1:0]  csr_prdata,
   output logic                            csr_pready,
   output prc_pkg::cfg_type                cfg
);

   prc_pkg::cfg_type cfg_ff;
   prc_pkg::cfg_type cfg_in;
   logic             write_en;
   logic [1:0]       reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            prc_pkg::REG_TILT_LOW:
               cfg_in.tilt_low = csr_pwdata[prc_pkg::TILT_WIDTH-1:0];
            prc_pkg::REG_TILT_HIGH:
               cfg_in.tilt_high = csr_pwdata[prc_pkg::TILT_WIDTH-1:0];
            prc_pkg::REG_KEY_MIN_HOLD:
               cfg_in.key_min_hold = csr_pwdata[prc_pkg::HOLD_WIDTH-1:0];
            prc_pkg::REG_IDLE_LIMIT:
               cfg_in.idle_limit = csr_pwdata[prc_pkg::IDLE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_index)
         prc_pkg::REG_TILT_LOW:
            csr_prdata[prc_pkg::TILT_WIDTH-1:0] = cfg_ff.tilt_low;
         prc_pkg::REG_TILT_HIGH:
            csr_prdata[prc_pkg::TILT_WIDTH-1:0] = cfg_ff.tilt_high;
         prc_pkg::REG_KEY_MIN_HOLD:
            csr_prdata[prc_pkg::HOLD_WIDTH-1:0] = cfg_ff.key_min_hold;
         prc_pkg::REG_IDLE_LIMIT:
            csr_prdata[prc_pkg::IDLE_WIDTH-1:0] = cfg_ff.idle_limit;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tilt_low     <= prc_pkg::TILT_LOW_RESET;
         cfg_ff.tilt_high    <= prc_pkg::TILT_HIGH_RESET;
         cfg_ff.key_min_hold <= prc_pkg::KEY_MIN_HOLD_RESET;
         cfg_ff.idle_limit   <= prc_pkg::IDLE_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/prc_tick.sv =====
module prc_tick (
   input  prc_pkg::cfg_type    cfg,
   input  prc_pkg::item_type   item,
   input  prc_pkg::state_type  state,
   output prc_pkg::state_type  state_next,
   output prc_pkg::result_type result
);

   always_comb begin
      prc_pkg::state_type   s;
      prc_pkg::pattern_type pat;
      logic [prc_pkg::HOLD_WIDTH:0] hold_sum;
      logic [prc_pkg::IDLE_WIDTH:0] idle_sum;
      logic toggle;
      logic sleep;
      logic [1:0] charge_state;

      s            = state;
      toggle       = 1'b0;
      sleep        = 1'b0;
      charge_state = prc_pkg::CHARGE_NONE;
      pat          = '0;

      // first tilt check
      if (prc_pkg::in_band(item.accel_z_first, cfg) &&
          s.vibe_mode == prc_pkg::VIBE_NONE && s.work_enabled) begin
         s.vibe_mode     = prc_pkg::VIBE_REMIND;
         s.pattern_ticks = '0;
      end

      // key debounce
      hold_sum = {1'b0, s.key_hold_count} + 9'd1;
      if (item.key_down) begin
         if (hold_sum >= {1'b0, prc_pkg::KEY_HOLD_CAP}) begin
            s.key_hold_count = prc_pkg::KEY_HOLD_CAP;
         end else begin
            s.key_hold_count = hold_sum[prc_pkg::HOLD_WIDTH-1:0];
         end
      end else begin
         toggle           = (s.key_hold_count >= cfg.key_min_hold);
         s.key_hold_count = '0;
      end
      if (toggle) begin
         if (s.work_enabled) begin
            s.work_enabled = 1'b0;
         end else begin
            s.work_enabled  = 1'b1;
            s.pattern_ticks = '0;
            s.vibe_mode     = prc_pkg::VIBE_STARTUP;
         end
      end

      // charger
      if (item.charging) begin
         s.work_enabled = 1'b0;
         charge_state   = item.charge_full ? prc_pkg::CHARGE_FULL : prc_pkg::CHARGE_BUSY;
      end

      // pattern step
      if (s.vibe_mode == prc_pkg::VIBE_STARTUP || s.vibe_mode == prc_pkg::VIBE_REMIND) begin
         s.pattern_ticks = s.pattern_ticks + 9'd1;
         pat = prc_pkg::pattern_lookup(s.vibe_mode == prc_pkg::VIBE_REMIND,
                                       s.pattern_ticks);
         if (pat.found) begin
            s.motor_level = pat.on;
         end else begin
            s.motor_level = 1'b0;
            s.vibe_mode   = prc_pkg::VIBE_NONE;
         end
      end

      // second tilt check
      if (prc_pkg::in_band(item.accel_z_second, cfg) &&
          s.vibe_mode == prc_pkg::VIBE_NONE && s.work_enabled) begin
         s.vibe_mode     = prc_pkg::VIBE_REMIND;
         s.pattern_ticks = '0;
      end

      // idle count
      idle_sum = {1'b0, s.idle_count} + 11'd1;
      if (!s.work_enabled && s.vibe_mode == prc_pkg::VIBE_NONE && s.key_hold_count == '0) begin
         if (idle_sum > {1'b0, cfg.idle_limit}) begin
            s.vibe_mode  = prc_pkg::VIBE_NONE;
            s.idle_count = '0;
            sleep        = 1'b1;
         end else begin
            s.idle_count = idle_sum[prc_pkg::IDLE_WIDTH-1:0];
         end
      end

      state_next           = s;
      result.motor_on      = s.motor_level;
      result.working       = s.work_enabled;
      result.charge_state  = charge_state;
      result.key_toggle    = toggle;
      result.tilt_seen     = prc_pkg::in_band(item.accel_z_second, cfg);
      result.sleep_request = sleep;
   end

endmodule

// ===== tb/sv/posture_reminder_controller_unit_tb.sv =====
module posture_reminder_controller_unit_tb;
   import prc_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int PRESSURE_CYCLES = 60;
   localparam int PRESSURE_AFTER  = 250;
   localparam int SETTLE_CYCLES   = 4;
   localparam int TAIL_CYCLES     = 8;
   localparam int BOOT_STEPS      = 7;
   localparam int NUDGE_STEPS     = 24;
   localparam int DIR_ROWS        = 21;
   localparam int PHASES          = 7;

   localparam logic [7:0] HOLD_CEILING = 8'd200;

   localparam logic [8:0] BOOT_EDGES [BOOT_STEPS] = '{
      9'd24, 9'd45, 9'd68, 9'd89, 9'd111, 9'd142, 9'd174
   };
   localparam logic [8:0] NUDGE_EDGES [NUDGE_STEPS] = '{
      9'd79,  9'd90,  9'd95,  9'd112, 9'd115, 9'd129, 9'd164, 9'd175,
      9'd180, 9'd197, 9'd200, 9'd214, 9'd249, 9'd260, 9'd265, 9'd282,
      9'd285, 9'd300, 9'd333, 9'd344, 9'd350, 9'd366, 9'd370, 9'd384
   };

   localparam result_type CALM = '0;

   typedef enum {PLAN_FIXED, PLAN_LONG, PLAN_WILD} plan_kind_type;
   typedef enum {FLOW_OPEN, FLOW_CHOPPY, FLOW_BLOCKED} flow_type;

   typedef struct {
      item_type   stim;
      logic       typed;
      result_type want;
   } tick_row_type;

   typedef struct {
      plan_kind_type kind;
      cfg_type       cfg;
      int            count;
   } phase_type;

   logic                  clock;
   logic                  reset              = 1'b1;
   logic                  req_valid          = 1'b0;
   logic                  req_ready;
   logic                  req_key_down       = 1'b0;
   logic                  req_charging       = 1'b0;
   logic                  req_charge_full    = 1'b0;
   logic [TILT_WIDTH-1:0] req_accel_z_first  = '0;
   logic [TILT_WIDTH-1:0] req_accel_z_second = '0;
   logic                  rsp_valid;
   logic                  rsp_ready          = 1'b0;
   logic                  rsp_motor_on;
   logic                  rsp_working;
   logic [1:0]            rsp_charge_state;
   logic                  rsp_key_toggle;
   logic                  rsp_tilt_seen;
   logic                  rsp_sleep_request;
   logic                  csr_psel           = 1'b0;
   logic                  csr_penable        = 1'b0;
   logic                  csr_pwrite         = 1'b0;
   logic [ADDR_WIDTH-1:0] csr_paddr          = '0;
   logic [DATA_WIDTH-1:0] csr_pwdata         = '0;
   logic [DATA_WIDTH-1:0] csr_prdata;
   logic                  csr_pready;

   state_type  ctl;
   cfg_type    ctl_cfg;
   result_type tick_results_due [$];
   int         mismatches    = 0;
   int         results_seen  = 0;
   int         cycle_count   = 0;
   int         burst_left    = 0;
   int         key_left      = 0;
   logic       key_level     = 1'b0;

   // key, charging, charge_full, z first, z second | typed | expected result
   tick_row_type dir_table [DIR_ROWS] = '{
      '{'{1'b0, 1'b0, 1'b0, 12'd0,    12'd0   }, 1'b1, CALM},
      '{'{1'b0, 1'b0, 1'b0, 12'd4095, 12'd4095}, 1'b1, CALM},
      '{'{1'b0, 1'b0, 1'b0, 12'd0,    12'd374 }, 1'b1, '{1'b0, 1'b0, CHARGE_NONE, 1'b0, 1'b1, 1'b0}},
      '{'{1'b0, 1'b0, 1'b0, 12'd374,  12'd373 }, 1'b1, CALM},
      '{'{1'b0, 1'b0, 1'b0, 12'd0,    12'd3695}, 1'b1, '{1'b0, 1'b0, CHARGE_NONE, 1'b0, 1'b1, 1'b0}},
      '{'{1'b0, 1'b0, 1'b0, 12'd0,    12'd3696}, 1'b1, CALM},
      '{'{1'b0, 1'b1, 1'b0, 12'd0,    12'd0   }, 1'b1, '{1'b0, 1'b0, CHARGE_BUSY, 1'b0, 1'b0, 1'b0}},
      '{'{1'b0, 1'b1, 1'b1, 12'd0,    12'd0   }, 1'b1, '{1'b0, 1'b0, CHARGE_FULL, 1'b0, 1'b0, 1'b0}},
      '{'{1'b0, 1'b0, 1'b1, 12'd4095, 12'd0   }, 1'b1, CALM},
      '{'{1'b1, 1'b0, 1'b0, 12'd0,    12'd0   }, 1'b0, CALM},
      '{'{1'b1, 1'b0, 1'b0, 12'd100,  12'd200 }, 1'b0, CALM},
      '{'{1'b1, 1'b0, 1'b0, 12'd0,    12'd0   }, 1'b0, CALM},
      '{'{1'b1, 1'b0, 1'b0, 12'd0,    12'd0   }, 1'b0, CALM},
      '{'{1'b1, 1'b0, 1'b0, 12'd0,    12'd0   }, 1'b0, CALM},
      '{'{1'b1, 1'b0, 1'b0, 12'd0,    12'd0   }, 1'b0, CALM},
      '{'{1'b1, 1'b0, 1'b0, 12'd0,    12'd0   }, 1'b0, CALM},
      '{'{1'b1, 1'b0, 1'b0, 12'd0,    12'd0   }, 1'b0, CALM},
      '{'{1'b0, 1'b0, 1'b0, 12'd0,    12'd0   }, 1'b0, CALM},
      '{'{1'b0, 1'b0, 1'b0, 12'd2000, 12'd2000}, 1'b0, CALM},
      '{'{1'b1, 1'b1, 1'b1, 12'd0,    12'd0   }, 1'b0, CALM},
      '{'{1'b0, 1'b0, 1'b0, 12'd0,    12'd0   }, 1'b0, CALM}
   };

   phase_type phases [PHASES] = '{
      '{PLAN_FIXED, '{12'd0,    12'd4095, 8'd1,   10'd1023}, 20},
      '{PLAN_FIXED, '{12'd4095, 12'd0,    8'd0,   10'd0   }, 15},
      '{PLAN_FIXED, '{12'd1000, 12'd3000, 8'd200, 10'd50  }, 15},
      '{PLAN_FIXED, '{12'd2000, 12'd2000, 8'd255, 10'd5   }, 15},
      '{PLAN_LONG,  '{12'd0,    12'd0,    8'd0,   10'd0   }, 530},
      '{PLAN_FIXED, '{12'd373,  12'd3696, 8'd8,   10'd1000}, 20},
      '{PLAN_WILD,  '{12'd0,    12'd0,    8'd0,   10'd0   }, 20}
   };

   posture_reminder_controller_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_key_down       (req_key_down),
      .req_charging       (req_charging),
      .req_charge_full    (req_charge_full),
      .req_accel_z_first  (req_accel_z_first),
      .req_accel_z_second (req_accel_z_second),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_motor_on       (rsp_motor_on),
      .rsp_working        (rsp_working),
      .rsp_charge_state   (rsp_charge_state),
      .rsp_key_toggle     (rsp_key_toggle),
      .rsp_tilt_seen      (rsp_tilt_seen),
      .rsp_sleep_request  (rsp_sleep_request),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   function automatic logic tilt_in_band(input logic [TILT_WIDTH-1:0] z);
      return (z > ctl_cfg.tilt_low) && (z < ctl_cfg.tilt_high);
   endfunction

   function automatic void arm_reminder(input logic [TILT_WIDTH-1:0] z);
      if (tilt_in_band(z) && ctl.vibe_mode == VIBE_NONE && ctl.work_enabled) begin
         ctl.vibe_mode     = VIBE_REMIND;
         ctl.pattern_ticks = '0;
      end
   endfunction

   // {inside a window, motor level}
   function automatic logic [1:0] window_drive(input logic remind, input logic [8:0] ticks);
      logic [8:0] limit_tick;
      int         steps;
      logic       first_on;
      steps    = remind ? NUDGE_STEPS : BOOT_STEPS;
      first_on = !remind;
      for (int i = 0; i < steps; i++) begin
         if (remind) limit_tick = NUDGE_EDGES[i];
         else limit_tick = BOOT_EDGES[i];
         if (ticks < limit_tick) return {1'b1, (i % 2 == 0) ? first_on : !first_on};
      end
      return 2'b00;
   endfunction

   function automatic result_type advance_controller(input item_type it);
      result_type r;
      logic [1:0] drive;
      int         next_idle;
      r = '0;
      arm_reminder(it.accel_z_first);

      if (it.key_down) begin
         ctl.key_hold_count = (ctl.key_hold_count >= HOLD_CEILING - 8'd1) ? HOLD_CEILING
                              : ctl.key_hold_count + 8'd1;
      end else begin
         r.key_toggle       = (ctl.key_hold_count >= ctl_cfg.key_min_hold);
         ctl.key_hold_count = '0;
      end
      if (r.key_toggle) begin
         if (ctl.work_enabled) begin
            ctl.work_enabled = 1'b0;
         end else begin
            ctl.work_enabled  = 1'b1;
            ctl.pattern_ticks = '0;
            ctl.vibe_mode     = VIBE_STARTUP;
         end
      end

      if (it.charging) begin
         ctl.work_enabled = 1'b0;
         r.charge_state   = it.charge_full ? CHARGE_FULL : CHARGE_BUSY;
      end

      if (ctl.vibe_mode != VIBE_NONE) begin
         ctl.pattern_ticks = ctl.pattern_ticks + 9'd1;
         drive = window_drive(ctl.vibe_mode == VIBE_REMIND, ctl.pattern_ticks);
         if (drive[1]) begin
            ctl.motor_level = drive[0];
         end else begin
            ctl.motor_level = 1'b0;
            ctl.vibe_mode   = VIBE_NONE;
         end
      end

      r.tilt_seen = tilt_in_band(it.accel_z_second);
      arm_reminder(it.accel_z_second);

      if (!ctl.work_enabled && ctl.vibe_mode == VIBE_NONE && ctl.key_hold_count == 0) begin
         next_idle = int'(ctl.idle_count) + 1;
         if (next_idle > int'(ctl_cfg.idle_limit)) begin
            ctl.work_enabled = 1'b0;
            ctl.vibe_mode    = VIBE_NONE;
            ctl.idle_count   = '0;
            r.sleep_request  = 1'b1;
         end else begin
            ctl.idle_count = 10'(next_idle);
         end
      end

      r.motor_on = ctl.motor_level;
      r.working  = ctl.work_enabled;
      return r;
   endfunction

   function automatic logic [TILT_WIDTH-1:0] pick_tilt();
      logic [TILT_WIDTH-1:0] z;
      int                    pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         case ($urandom_range(0, 5))
            0: z = 12'd0;
            1: z = 12'd4095;
            2: z = ctl_cfg.tilt_low;
            3: z = ctl_cfg.tilt_low + 12'd1;
            4: z = ctl_cfg.tilt_high - 12'd1;
            default: z = ctl_cfg.tilt_high;
         endcase
      end else if (pick < 4 || int'(ctl_cfg.tilt_high) <= int'(ctl_cfg.tilt_low) + 1) begin
         z = 12'($urandom);
      end else begin
         z = 12'($urandom_range(int'(ctl_cfg.tilt_low) + 1, int'(ctl_cfg.tilt_high) - 1));
      end
      return z;
   endfunction

   // long plan: switch on, let start-up and a reminder run, hold the key to
   // saturation during the reminder with the charger cutting in, then release
   function automatic item_type draw_item(input int n, input plan_kind_type kind);
      item_type it;
      int       hold;
      hold = int'(ctl_cfg.key_min_hold);
      it.accel_z_first  = pick_tilt();
      it.accel_z_second = pick_tilt();
      it.charge_full    = 1'($urandom);
      it.charging       = ($urandom_range(0, 19) == 0);
      if (kind == PLAN_LONG && n <= 506) begin
         it.key_down = (n < hold + 2) || (n >= 300 && n < 506);
         if (n < 300 || n == 506) it.charging = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         it.key_down = 1'($urandom);
      end else begin
         if (key_left == 0) begin
            key_level = !key_level;
            if (key_level) key_left = $urandom_range(0, 1) ? $urandom_range(1, hold + 2)
                                      : hold + $urandom_range(0, 3);
            else key_left = $urandom_range(1, 12);
            if (key_left == 0) key_left = 1;
         end
         key_left--;
         it.key_down = key_level;
      end
      return it;
   endfunction

   task automatic csr_write(input logic [1:0] idx, input int value);
      logic [DATA_WIDTH-1:0] mask;
      logic [DATA_WIDTH-1:0] kept;
      case (idx)
         REG_TILT_LOW:     mask = 32'h0000_0FFF;
         REG_TILT_HIGH:    mask = 32'h0000_0FFF;
         REG_KEY_MIN_HOLD: mask = 32'h0000_00FF;
         default:          mask = 32'h0000_03FF;
      endcase
      kept = 32'(value) & mask;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= kept | ($urandom & ~mask);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== kept) begin
         $error("csr register %0d: expected %0h, actual %0h", idx, kept, csr_prdata);
         mismatches++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_TILT_LOW:     ctl_cfg.tilt_low     = kept[TILT_WIDTH-1:0];
         REG_TILT_HIGH:    ctl_cfg.tilt_high    = kept[TILT_WIDTH-1:0];
         REG_KEY_MIN_HOLD: ctl_cfg.key_min_hold = kept[HOLD_WIDTH-1:0];
         default:          ctl_cfg.idle_limit   = kept[IDLE_WIDTH-1:0];
      endcase
      @(posedge clock);
   endtask

   task automatic offer_tick(input item_type it, input logic typed, input result_type want);
      result_type predicted;
      req_valid          <= 1'b1;
      req_key_down       <= it.key_down;
      req_charging       <= it.charging;
      req_charge_full    <= it.charge_full;
      req_accel_z_first  <= it.accel_z_first;
      req_accel_z_second <= it.accel_z_second;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = advance_controller(it);
      tick_results_due.push_back(typed ? want : predicted);
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                      : $urandom_range(0, 12);
      end
   endtask

   // receiver: check each item, then pick the next ready level
   initial begin
      result_type got;
      result_type exp;
      flow_type   flow;
      int         flow_left;
      int         hold_off;
      logic       pressure_done;
      flow_left     = 0;
      hold_off      = 0;
      pressure_done = 1'b0;
      flow          = FLOW_OPEN;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = {rsp_motor_on, rsp_working, rsp_charge_state, rsp_key_toggle,
                   rsp_tilt_seen, rsp_sleep_request};
            results_seen++;
            if (tick_results_due.size() == 0) begin
               $error("result item with nothing pending: %b", got);
               mismatches++;
            end else begin
               exp = tick_results_due.pop_front();
               if (got.motor_on !== exp.motor_on) begin
                  $error("motor_on: expected %0d, actual %0d", exp.motor_on, got.motor_on);
                  mismatches++;
               end
               if (got.working !== exp.working) begin
                  $error("working: expected %0d, actual %0d", exp.working, got.working);
                  mismatches++;
               end
               if (got.charge_state !== exp.charge_state) begin
                  $error("charge_state: expected %0d, actual %0d",
                         exp.charge_state, got.charge_state);
                  mismatches++;
               end
               if (got.key_toggle !== exp.key_toggle) begin
                  $error("key_toggle: expected %0d, actual %0d", exp.key_toggle, got.key_toggle);
                  mismatches++;
               end
               if (got.tilt_seen !== exp.tilt_seen) begin
                  $error("tilt_seen: expected %0d, actual %0d", exp.tilt_seen, got.tilt_seen);
                  mismatches++;
               end
               if (got.sleep_request !== exp.sleep_request) begin
                  $error("sleep_request: expected %0d, actual %0d",
                         exp.sleep_request, got.sleep_request);
                  mismatches++;
               end
            end
         end

         if (hold_off > 0) begin
            hold_off--;
            rsp_ready <= 1'b0;
         end else if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
            pressure_done = 1'b1;
            hold_off      = PRESSURE_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            if (flow_left == 0) begin
               case ($urandom_range(0, 3))
                  0, 1: begin
                     flow      = FLOW_OPEN;
                     flow_left = $urandom_range(10, 60);
                  end
                  2: begin
                     flow      = FLOW_CHOPPY;
                     flow_left = $urandom_range(10, 40);
                  end
                  default: begin
                     flow      = FLOW_BLOCKED;
                     flow_left = $urandom_range(1, 6);
                  end
               endcase
            end
            flow_left--;
            case (flow)
               FLOW_OPEN:   rsp_ready <= 1'b1;
               FLOW_CHOPPY: rsp_ready <= ($urandom_range(0, 2) != 0);
               default:     rsp_ready <= 1'b0;
            endcase
         end
      end
   end

   initial begin
      cfg_type next_cfg;
      ctl     = '0;
      ctl_cfg = '{12'd373, 12'd3696, 8'd8, 10'd1000};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         offer_tick(dir_table[i].stim, dir_table[i].typed, dir_table[i].want);
         pace_sender();
      end

      foreach (phases[p]) begin
         req_valid <= 1'b0;
         while (tick_results_due.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         next_cfg = phases[p].cfg;
         case (phases[p].kind)
            PLAN_LONG: begin
               next_cfg.tilt_low     = 12'($urandom_range(0, 1500));
               next_cfg.tilt_high    = 12'($urandom_range(2500, 4095));
               next_cfg.key_min_hold = 8'($urandom_range(2, 6));
               next_cfg.idle_limit   = 10'($urandom_range(300, 1023));
            end
            PLAN_WILD: begin
               next_cfg.tilt_low     = 12'($urandom);
               next_cfg.tilt_high    = 12'($urandom);
               next_cfg.key_min_hold = 8'($urandom);
               next_cfg.idle_limit   = 10'($urandom);
            end
            default: ;
         endcase
         csr_write(REG_TILT_LOW, int'(next_cfg.tilt_low));
         csr_write(REG_TILT_HIGH, int'(next_cfg.tilt_high));
         csr_write(REG_KEY_MIN_HOLD, int'(next_cfg.key_min_hold));
         csr_write(REG_IDLE_LIMIT, int'(next_cfg.idle_limit));
         key_left  = 0;
         key_level = 1'b0;
         for (int n = 0; n < phases[p].count; n++) begin
            offer_tick(draw_item(n, phases[p].kind), 1'b0, CALM);
            if (n != phases[p].count - 1) pace_sender();
         end
      end

      req_valid <= 1'b0;
      while (tick_results_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
